// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rgb pwm driver rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every clock edge outside reset
`define RGBPWM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// implication checked at every clock edge, reset included
`define RGBPWM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/rgbpwm_pkg.sv =====
// types and constants for the rgb color wheel pwm driver
package rgbpwm_pkg;

    localparam int LEVEL_W = 8;
    localparam int SLOT_W  = 8;
    localparam int MODE_W  = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'hFF;
    localparam logic [LEVEL_W-1:0] LEVEL_MIN = 8'h00;
    localparam logic [SLOT_W-1:0]  SLOT_LAST = 8'd254;

    localparam logic [MODE_W-1:0] MODE_DEBUG   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RAINBOW = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SOLID   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_PULSE   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIODS = 1'd1;

    localparam logic [MODE_W-1:0] MODE_RESET    = MODE_RAINBOW;
    localparam logic [SLOT_W-1:0] PERIODS_RESET = 8'd15;

    typedef struct packed {
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
    } t_rgb;

    localparam t_rgb LEVEL_RESET = '{red: LEVEL_MAX, green: LEVEL_MIN, blue: LEVEL_MIN};

endpackage

// ===== rtl/rgbpwm_fade.sv =====
// color wheel fade rules applied in order on the three levels
module rgbpwm_fade import rgbpwm_pkg::*; (
    input  logic i_enable,
    input  t_rgb i_level,
    output t_rgb o_level
);

    always_comb begin
        t_rgb v;
        v = i_level;
        if (i_enable) begin
            // blue to red
            if (v.blue > LEVEL_MIN && v.red == LEVEL_MAX && v.green == LEVEL_MIN) begin
                v.blue = v.blue - 8'd1;
            end
            if (v.blue == LEVEL_MAX && v.red < LEVEL_MAX && v.green == LEVEL_MIN) begin
                v.red = v.red + 8'd1;
            end
            // green to blue
            if (v.green > LEVEL_MIN && v.blue == LEVEL_MAX && v.red == LEVEL_MIN) begin
                v.green = v.green - 8'd1;
            end
            if (v.green == LEVEL_MAX && v.blue < LEVEL_MAX && v.red == LEVEL_MIN) begin
                v.blue = v.blue + 8'd1;
            end
            // red to green
            if (v.red > LEVEL_MIN && v.green == LEVEL_MAX && v.blue == LEVEL_MIN) begin
                v.red = v.red - 8'd1;
            end
            if (v.red == LEVEL_MAX && v.green < LEVEL_MAX && v.blue == LEVEL_MIN) begin
                v.green = v.green + 8'd1;
            end
        end
        o_level = v;
    end

endmodule

// ===== rtl/rgbpwm_timer.sv =====
// pwm slot counter and period group counter
module rgbpwm_timer import rgbpwm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [SLOT_W-1:0] i_periods,
    output logic [SLOT_W-1:0] o_slot,
    output logic              o_group_start
);

    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [SLOT_W-1:0] r_period, n_period;
    logic [SLOT_W-1:0] period_inc;

    assign period_inc = r_period + 8'd1;

    always_comb begin
        n_slot   = r_slot;
        n_period = r_period;
        if (i_step) begin
            if (r_slot == SLOT_LAST) begin
                n_slot   = '0;
                n_period = (period_inc == i_periods) ? '0 : period_inc;
            end else begin
                n_slot = r_slot + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot   <= '0;
            r_period <= '0;
        end else begin
            r_slot   <= n_slot;
            r_period <= n_period;
        end
    end

    assign o_slot        = r_slot;
    assign o_group_start = (r_slot == '0) && (r_period == '0);

endmodule

// ===== rtl/rgb_rainbow_pwm_driver_core.sv =====
// top level of the rgb color wheel pwm driver
// an accepted item's result is registered into the output register in the cycle after it is accepted
// throughput: one item per cycle; o_stall rises only while a result waits and i_stall is high
// the fade rules, pin compares and counter updates sit between state and output registers
// reset: synchronous active low; levels return to full red, counters to zero,
// mode to rainbow fade and the step period to fifteen
module rgb_rainbow_pwm_driver_core import rgbpwm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_advance,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_red_pin,
    output logic                  o_green_pin,
    output logic                  o_blue_pin,
    output logic [LEVEL_W-1:0]    o_red_now,
    output logic [LEVEL_W-1:0]    o_green_now,
    output logic [LEVEL_W-1:0]    o_blue_now,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

`include "assert_macros.svh"

    logic [MODE_W-1:0] r_mode;
    logic [SLOT_W-1:0] r_periods;
    t_rgb              r_level, n_level, fade_level;
    logic              accept, step, group_start, fade_en;
    logic [SLOT_W-1:0] slot;
    logic              r_out_valid;
    t_rgb              r_out_level;
    logic [2:0]        r_out_pins;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_RESET;
            r_periods <= PERIODS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MODE:    r_mode    <= i_cfg_data[MODE_W-1:0];
                CFG_PERIODS: r_periods <= i_cfg_data[SLOT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_stall = r_out_valid & i_stall;
    assign accept  = i_valid & ~o_stall;
    assign step    = accept & i_advance;
    assign fade_en = step & group_start & (r_mode == MODE_RAINBOW);

    rgbpwm_timer u_timer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_periods     (r_periods),
        .o_slot        (slot),
        .o_group_start (group_start)
    );

    rgbpwm_fade u_fade (
        .i_enable (fade_en),
        .i_level  (r_level),
        .o_level  (fade_level)
    );

    assign n_level = fade_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= LEVEL_RESET;
        end else begin
            r_level <= n_level;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_level <= n_level;
            r_out_pins  <= {slot < n_level.red, slot < n_level.green, slot < n_level.blue};
        end
    end

    assign o_valid     = r_out_valid;
    assign o_red_pin   = r_out_pins[2];
    assign o_green_pin = r_out_pins[1];
    assign o_blue_pin  = r_out_pins[0];
    assign o_red_now   = r_out_level.red;
    assign o_green_now = r_out_level.green;
    assign o_blue_now  = r_out_level.blue;

    `RGBPWM_ASSERT(a_slot_range, slot != 8'd255, "slot counter left its range")
    `RGBPWM_ASSERT(a_accept_gives_result, accept |=> o_valid, "accepted item gave no result")
    `RGBPWM_ASSERT(a_levels_hold, !step |=> $stable(r_level), "levels changed without a step")
    `RGBPWM_ASSERT(a_fade_only_rainbow, (r_mode != MODE_RAINBOW) |-> (fade_level == r_level),
        "levels faded outside rainbow mode")
    `RGBPWM_ASSERT_ALWAYS(a_stall_needs_result, o_stall |-> o_valid,
        "input stalled with no result waiting")

endmodule

// ===== sim/tb_rgb_rainbow_pwm_driver_core.sv =====
// self-checking testbench for the rgb color wheel pwm driver core
module tb_rgb_rainbow_pwm_driver_core;
    import rgbpwm_pkg::*;

    typedef struct packed {
        logic red_pin;
        logic green_pin;
        logic blue_pin;
        t_rgb level;
    } t_pwm_out;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic                  adv;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        bit                    typed;
        t_pwm_out              want;
    } t_dir_row;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  i_advance   = 1'b0;
    logic                  i_stall     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_stall;
    logic                  o_valid;
    logic                  o_red_pin;
    logic                  o_green_pin;
    logic                  o_blue_pin;
    logic [LEVEL_W-1:0]    o_red_now;
    logic [LEVEL_W-1:0]    o_green_now;
    logic [LEVEL_W-1:0]    o_blue_now;

    // predictor state
    t_rgb                  lvl_m;
    logic [SLOT_W-1:0]     slot_m;
    logic [SLOT_W-1:0]     period_m;
    logic [MODE_W-1:0]     mode_m;
    logic [CFG_DATA_W-1:0] per_step_m;

    t_pwm_out pending_q[$];
    int       n_fail        = 0;
    int       snd_idle_pct  = 0;
    int       rcv_stall_pct = 0;
    int       hold_len      = 0;

    t_dir_row dir_tab [0:22] = '{
        '{ROW_ITEM, 1'b0, '0, '0, 1'b1, {1'b1, 1'b0, 1'b0, 8'd255, 8'd0, 8'd0}},
        '{ROW_ITEM, 1'b1, '0, '0, 1'b1, {1'b1, 1'b1, 1'b0, 8'd255, 8'd1, 8'd0}},
        '{ROW_ITEM, 1'b1, '0, '0, 1'b1, {1'b1, 1'b0, 1'b0, 8'd255, 8'd1, 8'd0}},
        '{ROW_ITEM, 1'b0, '0, '0, 1'b1, {1'b1, 1'b0, 1'b0, 8'd255, 8'd1, 8'd0}},
        '{ROW_CFG,  1'b0, CFG_MODE, {6'h3F, MODE_DEBUG}, 1'b0, '0},
        '{ROW_ITEM, 1'b1, '0, '0, 1'b0, '0},
        '{ROW_ITEM, 1'b0, '0, '0, 1'b0, '0},
        '{ROW_CFG,  1'b0, CFG_MODE, {6'h2A, MODE_SOLID}, 1'b0, '0},
        '{ROW_ITEM, 1'b1, '0, '0, 1'b0, '0},
        '{ROW_CFG,  1'b0, CFG_MODE, {6'h15, MODE_PULSE}, 1'b0, '0},
        '{ROW_ITEM, 1'b1, '0, '0, 1'b0, '0},
        '{ROW_CFG,  1'b0, CFG_MODE, {6'h00, MODE_RAINBOW}, 1'b0, '0},
        '{ROW_CFG,  1'b0, CFG_PERIODS, 8'd1, 1'b0, '0},
        '{ROW_ITEM, 1'b1, '0, '0, 1'b0, '0},
        '{ROW_ITEM, 1'b1, '0, '0, 1'b0, '0},
        '{ROW_CFG,  1'b0, CFG_PERIODS, 8'd255, 1'b0, '0},
        '{ROW_ITEM, 1'b1, '0, '0, 1'b0, '0},
        '{ROW_CFG,  1'b0, CFG_PERIODS, 8'd0, 1'b0, '0},
        '{ROW_ITEM, 1'b1, '0, '0, 1'b0, '0},
        '{ROW_ITEM, 1'b0, '0, '0, 1'b0, '0},
        '{ROW_CFG,  1'b0, CFG_PERIODS, 8'd15, 1'b0, '0},
        '{ROW_ITEM, 1'b1, '0, '0, 1'b0, '0},
        '{ROW_ITEM, 1'b0, '0, '0, 1'b0, '0}
    };

    rgb_rainbow_pwm_driver_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_advance   (i_advance),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_red_pin   (o_red_pin),
        .o_green_pin (o_green_pin),
        .o_blue_pin  (o_blue_pin),
        .o_red_now   (o_red_now),
        .o_green_now (o_green_now),
        .o_blue_now  (o_blue_now),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    function automatic t_rgb wheel_fade(input t_rgb c);
        if (c.blue > 8'd0 && c.red == 8'hFF && c.green == 8'h00) c.blue = c.blue - 8'd1;
        if (c.blue == 8'hFF && c.red < 8'hFF && c.green == 8'h00) c.red = c.red + 8'd1;
        if (c.green > 8'd0 && c.blue == 8'hFF && c.red == 8'h00) c.green = c.green - 8'd1;
        if (c.green == 8'hFF && c.blue < 8'hFF && c.red == 8'h00) c.blue = c.blue + 8'd1;
        if (c.red > 8'd0 && c.green == 8'hFF && c.blue == 8'h00) c.red = c.red - 8'd1;
        if (c.red == 8'hFF && c.green < 8'hFF && c.blue == 8'h00) c.green = c.green + 8'd1;
        return c;
    endfunction

    function automatic t_pwm_out pwm_tick(input logic adv);
        t_pwm_out r;
        if (adv && slot_m == 8'd0 && period_m == 8'd0 && mode_m == MODE_RAINBOW) begin
            lvl_m = wheel_fade(lvl_m);
        end
        r.red_pin   = slot_m < lvl_m.red;
        r.green_pin = slot_m < lvl_m.green;
        r.blue_pin  = slot_m < lvl_m.blue;
        r.level     = lvl_m;
        if (adv) begin
            if (slot_m == 8'd254) begin
                slot_m   = 8'd0;
                period_m = period_m + 8'd1;
                if (period_m == per_step_m) period_m = 8'd0;
            end else begin
                slot_m = slot_m + 8'd1;
            end
        end
        return r;
    endfunction

    // called and returns at a falling edge
    task automatic offer_item(input logic adv, input bit typed, input t_pwm_out want);
        logic     taken;
        t_pwm_out r;
        while ($urandom_range(99) < snd_idle_pct) begin
            i_valid   <= 1'b0;
            i_advance <= 1'($urandom_range(1));
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_advance <= adv;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !o_stall;
            if (taken) begin
                r = pwm_tick(adv);
                pending_q.push_back(typed ? want : r);
            end
            @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_valid <= 1'b0;
        while (pending_q.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        if (idx == CFG_MODE) mode_m = val[MODE_W-1:0];
        else per_step_m = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_items(input int n, input int adv_pct);
        repeat (n) offer_item($urandom_range(99) < adv_pct, 1'b0, '0);
    endtask

    task automatic check_field(input string name, input logic [LEVEL_W-1:0] want,
                               input logic [LEVEL_W-1:0] got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endtask

    always @(negedge i_clk) begin
        if (hold_len > 0) begin
            i_stall <= 1'b1;
            hold_len = hold_len - 1;
        end else begin
            i_stall <= ($urandom_range(99) < rcv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_pwm_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_q.size() == 0) begin
                $error("result with no item pending");
                n_fail++;
            end else begin
                want = pending_q.pop_front();
                check_field("red_pin", LEVEL_W'(want.red_pin), LEVEL_W'(o_red_pin));
                check_field("green_pin", LEVEL_W'(want.green_pin), LEVEL_W'(o_green_pin));
                check_field("blue_pin", LEVEL_W'(want.blue_pin), LEVEL_W'(o_blue_pin));
                check_field("red_now", want.level.red, o_red_now);
                check_field("green_now", want.level.green, o_green_now);
                check_field("blue_now", want.level.blue, o_blue_now);
            end
        end
    end

    initial begin
        #32000000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        int                    ph;
        int                    k;
        logic [CFG_DATA_W-1:0] dat;
        lvl_m      = '{red: 8'd255, green: 8'd0, blue: 8'd0};
        slot_m     = 8'd0;
        period_m   = 8'd0;
        mode_m     = MODE_RAINBOW;
        per_step_m = 8'd15;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_tab[r]) begin
            if (dir_tab[r].kind == ROW_CFG) write_reg(dir_tab[r].idx, dir_tab[r].data);
            else offer_item(dir_tab[r].adv, dir_tab[r].typed, dir_tab[r].want);
        end

        // rainbow fade with one period per step
        write_reg(CFG_MODE, {6'h00, MODE_RAINBOW});
        write_reg(CFG_PERIODS, 8'd1);
        run_items(120, 98);

        // zero period register
        write_reg(CFG_PERIODS, 8'd0);
        run_items(40, 100);

        // period register lowered mid-group
        write_reg(CFG_PERIODS, 8'd255);
        run_items(40, 100);
        write_reg(CFG_PERIODS, 8'd2);
        run_items(60, 100);

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    snd_idle_pct  = 0;
                    rcv_stall_pct = 0;
                end
                1: begin
                    snd_idle_pct  = 74;
                    rcv_stall_pct = 0;
                end
                2: begin
                    snd_idle_pct  = 0;
                    rcv_stall_pct = 74;
                end
                default: begin
                    snd_idle_pct  = 28;
                    rcv_stall_pct = 28;
                end
            endcase
            for (k = 0; k < 3; k++) begin
                dat = 8'($urandom_range(255));
                write_reg(CFG_MODE, dat);
                if ($urandom_range(3) == 0) dat = 8'($urandom_range(255));
                else dat = 8'($urandom_range(3, 1));
                write_reg(CFG_PERIODS, dat);
                // long receiver hold-off while items keep coming
                if (ph == 0 && k == 1) hold_len = 300;
                run_items(80, 80);
            end
        end

        i_valid <= 1'b0;
        while (pending_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (pending_q.size() != 0) begin
            $error("%0d results never arrived", pending_q.size());
            n_fail++;
        end
        if (n_fail == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/rgbpwm_pkg.sv
rtl/rgbpwm_fade.sv
rtl/rgbpwm_timer.sv
rtl/rgb_rainbow_pwm_driver_core.sv
sim/tb_rgb_rainbow_pwm_driver_core.sv
